// ----- rtl/core/scfr_pkg.sv -----
// Shared types, constants and helpers for the checksummed frame receiver.
package scfr_pkg;

  // Frame header and acknowledge constants
  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'hAF;
  localparam logic [7:0] ACK_HDR    = 8'hAA;
  localparam logic [7:0] ACK_FUNC   = 8'hEF;
  localparam logic [7:0] ACK_LEN    = 8'h02;

  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd20;

  // Acknowledge frame is seven bytes long
  localparam int unsigned ACK_BYTES = 7;
  localparam int unsigned ACK_IDX_W = $clog2(ACK_BYTES);
  localparam logic [ACK_IDX_W-1:0] ACK_LAST_IDX = ACK_IDX_W'(ACK_BYTES - 1);

  // Byte positions within the acknowledge frame
  localparam logic [ACK_IDX_W-1:0] AB_HDR0 = ACK_IDX_W'(0);
  localparam logic [ACK_IDX_W-1:0] AB_HDR1 = ACK_IDX_W'(1);
  localparam logic [ACK_IDX_W-1:0] AB_FUNC = ACK_IDX_W'(2);
  localparam logic [ACK_IDX_W-1:0] AB_LEN  = ACK_IDX_W'(3);
  localparam logic [ACK_IDX_W-1:0] AB_CODE = ACK_IDX_W'(4);
  localparam logic [ACK_IDX_W-1:0] AB_SUM  = ACK_IDX_W'(5);

  // Parser phases
  typedef enum logic [2:0] {
    PH_WAIT_A  = 3'd0,
    PH_WAIT_B  = 3'd1,
    PH_FUNC    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SUM     = 3'd5
  } phase_t;

  // Acknowledge request from parser to transmitter
  typedef struct packed {
    logic       vld;
    logic [7:0] func;
    logic [7:0] sum;
  } ack_req_t;

  // One byte of the acknowledge frame
  function automatic logic [7:0] ack_byte(input logic [ACK_IDX_W-1:0] idx,
                                          input logic [7:0] func,
                                          input logic [7:0] sum);
    logic [7:0] total;
    total = ACK_HDR + ACK_HDR + ACK_FUNC + ACK_LEN + func + sum;
    unique case (idx)
      AB_HDR0: ack_byte = ACK_HDR;
      AB_HDR1: ack_byte = ACK_HDR;
      AB_FUNC: ack_byte = ACK_FUNC;
      AB_LEN:  ack_byte = ACK_LEN;
      AB_CODE: ack_byte = func;
      AB_SUM:  ack_byte = sum;
      default: ack_byte = total;
    endcase
  endfunction

endpackage

// ----- rtl/core/scfr_parser.sv -----
// Frame parser: tracks phase, length, function and running sum per byte.
module scfr_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        in_rx_byte,
  input  logic [7:0]        max_payload,
  output scfr_pkg::ack_req_t ack_req
);
  import scfr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] func_r, func_nxt;
  logic       good;

  // Next-state logic for one accepted byte
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    func_nxt  = func_r;
    good      = 1'b0;
    if (in_accept) begin
      unique case (phase_r)
        PH_WAIT_B: begin
          if (in_rx_byte == HDR_SECOND) begin
            sum_nxt   = sum_r + in_rx_byte;
            phase_nxt = PH_FUNC;
          end else begin
            phase_nxt = PH_WAIT_A;
            sum_nxt   = '0;
            len_nxt   = '0;
          end
        end
        PH_FUNC: begin
          func_nxt  = in_rx_byte;
          sum_nxt   = sum_r + in_rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (in_rx_byte > max_payload) begin
            phase_nxt = PH_WAIT_A;
            sum_nxt   = '0;
            len_nxt   = '0;
          end else begin
            len_nxt   = in_rx_byte;
            sum_nxt   = sum_r + in_rx_byte;
            phase_nxt = (in_rx_byte == 8'd0) ? PH_SUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt = sum_r + in_rx_byte;
          len_nxt = len_r - 8'd1;
          if (len_r == 8'd1) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          good      = (in_rx_byte == sum_r);
          phase_nxt = PH_WAIT_A;
          sum_nxt   = '0;
          len_nxt   = '0;
        end
        default: begin
          // waiting for first header byte
          len_nxt = '0;
          if (in_rx_byte == HDR_FIRST) begin
            sum_nxt   = in_rx_byte;
            phase_nxt = PH_WAIT_B;
          end else begin
            sum_nxt   = '0;
            phase_nxt = PH_WAIT_A;
          end
        end
      endcase
    end
  end

  // Request to the transmitter carries the frame's function and sum
  always_comb begin
    ack_req.vld  = good;
    ack_req.func = func_r;
    ack_req.sum  = sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_A;
      sum_r   <= '0;
      len_r   <= '0;
      func_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
      func_r  <= func_nxt;
    end
  end

  // Payload phase always has bytes outstanding
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> len_r != 8'd0)
    else $error("payload phase with zero length");

  // Sum is cleared whenever the parser waits for the first header byte
  a_idle_sum: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAIT_A |-> sum_r == 8'd0)
    else $error("running sum not cleared while idle");

endmodule

// ----- rtl/core/scfr_ack_tx.sv -----
// Acknowledge transmitter: request slot, byte sequencer and output register.
module scfr_ack_tx (
  input  logic               clk,
  input  logic               rst_n,
  input  scfr_pkg::ack_req_t ack_req,
  output logic               slot_full,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_ack_last
);
  import scfr_pkg::*;

  logic                 slot_full_r;
  logic [7:0]           slot_func_r, slot_sum_r;
  logic                 active_r;
  logic [ACK_IDX_W-1:0] idx_r;
  logic [7:0]           func_r, sum_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;

  logic out_free, adv, last_adv, take;

  // Handshake between slot, sequencer and output register
  assign out_free = !out_valid_r || out_ready;
  assign adv      = active_r && out_free;
  assign last_adv = adv && (idx_r == ACK_LAST_IDX);
  assign take     = slot_full_r && (!active_r || last_adv);

  // Pending request slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_full_r <= 1'b0;
    end else if (ack_req.vld) begin
      slot_full_r <= 1'b1;
    end else if (take) begin
      slot_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack_req.vld) begin
      slot_func_r <= ack_req.func;
      slot_sum_r  <= ack_req.sum;
    end
  end

  // Byte sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (take) begin
      active_r <= 1'b1;
      idx_r    <= '0;
    end else if (last_adv) begin
      active_r <= 1'b0;
    end else if (adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      func_r <= slot_func_r;
      sum_r  <= slot_sum_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= ack_byte(idx_r, func_r, sum_r);
      out_last_r <= (idx_r == ACK_LAST_IDX);
    end
  end

  // Slot counts as free in the cycle its request moves to the sequencer
  assign slot_full    = slot_full_r && !take;
  assign out_valid    = out_valid_r;
  assign out_tx_byte  = out_byte_r;
  assign out_ack_last = out_last_r;

  // A new request never lands on an occupied slot
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ack_req.vld |-> !slot_full_r)
    else $error("acknowledge request overran the slot");

  // Sequencer index stays inside the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> idx_r <= ACK_LAST_IDX)
    else $error("acknowledge index out of range");

  // An idle sequencer picks up a waiting request at once
  a_pickup: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_full_r && !active_r) |=> active_r)
    else $error("pending acknowledge not started");

endmodule

// ----- rtl/core/sum_checked_frame_receiver.sv -----
// Top level of the checksummed serial frame receiver.
//
// Input channel (in_valid/in_ready/in_rx_byte): one received byte per
// request. Frames are AA AF, function, length, payload, sum; the sum byte
// must match the mod-256 sum of all earlier frame bytes. Lengths above the
// configured maximum abort the frame.
// Output channel (out_valid/out_ready/out_tx_byte/out_ack_last): a good
// frame yields a seven-byte acknowledge AA AA EF 02, function, sum, total;
// out_ack_last marks the final byte.
// cfg_we/cfg_wdata write max_payload (reset value 20), used at length bytes.
// Throughput: one input byte per cycle while in_ready is high. Acknowledges
// pass slot, sequencer and output register, then leave one byte per cycle
// while out_ready is high. in_ready drops only while a finished acknowledge
// waits in the single request slot behind one still being sent; a stalled
// receiver therefore holds off input only once a second good frame completes.
// Reset (rst_n, synchronous, active low) returns the parser to waiting for
// the first header byte and discards any acknowledge in flight.
module sum_checked_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_ack_last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import scfr_pkg::*;

  logic       max_payload_r;
  logic [7:0] max_pl_r;
  logic       slot_full;
  logic       in_accept;
  ack_req_t   ack_req;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pl_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_pl_r <= cfg_wdata;
    end
  end

  // Track that the register has been written since reset (status only)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 1'b0;
    end else if (cfg_we) begin
      max_payload_r <= 1'b1;
    end
  end

  assign in_ready  = !slot_full;
  assign in_accept = in_valid && in_ready;

  scfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_rx_byte  (in_rx_byte),
    .max_payload (max_pl_r),
    .ack_req     (ack_req)
  );

  scfr_ack_tx u_ack_tx (
    .clk          (clk),
    .rst_n        (rst_n),
    .ack_req      (ack_req),
    .slot_full    (slot_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tx_byte  (out_tx_byte),
    .out_ack_last (out_ack_last)
  );

  // Register keeps its reset value until the first write
  a_cfg_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !max_payload_r |-> max_pl_r == MAX_PAYLOAD_RST)
    else $error("max payload changed without a write");

  // No byte is taken while an acknowledge request is still parked
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    slot_full |-> !in_accept)
    else $error("byte accepted with request slot full");

  // Output request holds steady while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_tx_byte) && $stable(out_ack_last)))
    else $error("output request changed while stalled");

endmodule

// ----- test/sum_checked_frame_receiver_tb.sv -----
// Self-checking testbench for the checksummed frame receiver and its acknowledge output.
module sum_checked_frame_receiver_tb;
  import scfr_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RST_CYCLES = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRINT_CAP = 40;

  // stimulus frame shapes
  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_HDR,
    FR_TOO_LONG
  } frame_kind_t;

  // one expected acknowledge byte
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } ack_beat_t;

  // Predicts the acknowledge bytes from the accepted receive bytes
  class ack_scoreboard;
    logic [7:0]  max_payload;
    phase_t      parse_phase;
    logic [7:0]  run_sum;
    logic [7:0]  remain;
    logic [7:0]  func_code;
    ack_beat_t   ack_fifo[$];
    int          errors;

    function new();
      max_payload = MAX_PAYLOAD_RST;
      func_code = 8'h00;
      errors = 0;
      restart_parse();
    endfunction

    function void restart_parse();
      parse_phase = PH_WAIT_A;
      run_sum = 8'h00;
      remain = 8'h00;
    endfunction

    function int pending();
      return ack_fifo.size();
    endfunction

    // AA AA EF 02, function, sum, total of the six
    function void queue_ack();
      logic [7:0] bytes[7];
      logic [7:0] total;
      bytes[0] = ACK_HDR;
      bytes[1] = ACK_HDR;
      bytes[2] = ACK_FUNC;
      bytes[3] = ACK_LEN;
      bytes[4] = func_code;
      bytes[5] = run_sum;
      total = 8'h00;
      for (int k = 0; k < 6; k++) total = total + bytes[k];
      bytes[6] = total;
      for (int k = 0; k < 7; k++) ack_fifo.push_back({bytes[k], k == 6});
    endfunction

    // advance the parser by one accepted request
    function void note_byte(logic [7:0] b);
      case (parse_phase)
        PH_WAIT_B: begin
          if (b == HDR_SECOND) begin
            run_sum = run_sum + b;
            parse_phase = PH_FUNC;
          end else begin
            restart_parse();
          end
        end
        PH_FUNC: begin
          func_code = b;
          run_sum = run_sum + b;
          parse_phase = PH_LEN;
        end
        PH_LEN: begin
          if (b > max_payload) begin
            restart_parse();
          end else begin
            remain = b;
            run_sum = run_sum + b;
            parse_phase = (b == 8'h00) ? PH_SUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          run_sum = run_sum + b;
          remain = remain - 8'h01;
          if (remain == 8'h00) parse_phase = PH_SUM;
        end
        PH_SUM: begin
          if (b == run_sum) queue_ack();
          restart_parse();
        end
        default: begin
          restart_parse();
          if (b == HDR_FIRST) begin
            run_sum = b;
            parse_phase = PH_WAIT_B;
          end
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one acknowledge byte against the oldest expectation
    task check_byte(logic [7:0] tx, logic last);
      ack_beat_t want;
      if (ack_fifo.size() == 0) begin
        report($sformatf("unexpected ack byte %h last %b", tx, last));
      end else begin
        want = ack_fifo.pop_front();
        if (tx !== want.tx)
          report($sformatf("tx_byte %h, expected %h", tx, want.tx));
        if (last !== want.last)
          report($sformatf("ack_last %b, expected %b (byte %h)", last, want.last, want.tx));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_tx_byte;
  logic       out_ack_last;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  ack_scoreboard sb = new();

  int          cycles = 0;
  int          n_sent = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 54;
  logic [7:0]  cur_max = MAX_PAYLOAD_RST;

  sum_checked_frame_receiver dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_tx_byte (out_tx_byte),
    .out_ack_last(out_ack_last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // observe both channels at the sampling edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready) sb.check_byte(out_tx_byte, out_ack_last);
    end
  end

  // one request on the input channel; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_payload(input logic [7:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    sb.max_payload = v;
    cur_max = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // build and send one frame of the given shape
  task automatic send_frame(input frame_kind_t kind, input logic [7:0] func,
                            input logic [7:0] len);
    logic [7:0] sum;
    logic [7:0] b;
    push_byte(HDR_FIRST);
    if (kind == FR_BAD_HDR) begin
      b = 8'($urandom);
      if (b == HDR_SECOND) b = ~b;
      push_byte(b);
    end else begin
      push_byte(HDR_SECOND);
      push_byte(func);
      push_byte(len);
      if (kind != FR_TOO_LONG) begin
        sum = HDR_FIRST + HDR_SECOND + func + len;
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          sum = sum + b;
          push_byte(b);
        end
        if (kind == FR_BAD_SUM) sum = sum + 8'($urandom_range(255, 1));
        push_byte(sum);
      end
    end
  endtask

  // mostly short payloads, now and then the full allowed length when it is at most 24
  function automatic logic [7:0] pick_len();
    int unsigned cap;
    cap = (cur_max < 6) ? cur_max : 6;
    if ($urandom_range(9) == 0 && cur_max <= 24) return cur_max;
    return 8'($urandom_range(cap, 0));
  endfunction

  task automatic run_random(input int n_items);
    int          target;
    int unsigned r;
    logic [7:0]  func;
    target = n_sent + n_items;
    while (n_sent < target) begin
      r = $urandom_range(99);
      func = 8'($urandom);
      if (r < 70) begin
        send_frame(FR_GOOD, func, pick_len());
      end else if (r < 80) begin
        send_frame(FR_BAD_SUM, func, pick_len());
      end else if (r < 87) begin
        send_frame(FR_BAD_HDR, func, 8'h00);
      end else if (r < 94 && cur_max != 8'hFF) begin
        send_frame(FR_TOO_LONG, func, 8'($urandom_range(255, cur_max + 1)));
      end else begin
        // line noise while hunting for a header
        push_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: shortest frame, all-ones function, broken header, bad sum, overlong
    send_frame(FR_GOOD, 8'h00, 8'h00);
    send_frame(FR_GOOD, 8'hFF, 8'h01);
    push_byte(HDR_FIRST);
    push_byte(HDR_FIRST);
    push_byte(HDR_SECOND);
    send_frame(FR_BAD_SUM, 8'h5A, 8'h00);
    send_frame(FR_TOO_LONG, 8'h11, MAX_PAYLOAD_RST + 8'd1);

    // limit changed part-way through a frame takes effect at the length byte
    wait_drained();
    push_byte(HDR_FIRST);
    push_byte(HDR_SECOND);
    push_byte(8'hC3);
    wait_drained();
    write_max_payload(8'h00);
    push_byte(8'h00);
    push_byte(HDR_FIRST + HDR_SECOND + 8'hC3);
    run_random(46);

    // sender idles more than the receiver, widest limit
    wait_drained();
    send_idle_pct = 54;
    recv_idle_pct = 13;
    write_max_payload(8'hFF);
    run_random(46);

    // no idling, random limit
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_payload(8'($urandom_range(30, 1)));
    run_random(46);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/scfr_pkg.sv
rtl/core/scfr_parser.sv
rtl/core/scfr_ack_tx.sv
rtl/core/sum_checked_frame_receiver.sv
test/sum_checked_frame_receiver_tb.sv
